FILE: rtl/wtach_pkg.sv
// Shared constants, register indexes and control types of the windowed tachometer.
package wtach_pkg;

   // Width of the rising-edge counter.
   localparam int COUNT_BITS = 24;
   // Widths of the result fields.
   localparam int PULSE_BITS = 24;
   localparam int RPM_BITS   = 30;
   // Configuration register width and index width.
   localparam int CFG_BITS       = 8;
   localparam int CSR_INDEX_BITS = 2;
   // Seconds counter width; it also sets the counter's ceiling.
   localparam int SEC_BITS = 8;
   // Dividend holds count*60, which needs six more bits than the count.
   localparam int DIV_BITS  = COUNT_BITS + 6;
   // Divisor holds window_seconds*pulses_per_rev.
   localparam int DVSR_BITS = 2 * CFG_BITS;
   // Iteration counter of the divider.
   localparam int STEP_BITS = $clog2(DIV_BITS);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_SECONDS = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_PULSES_PER_REV = CSR_INDEX_BITS'(1);

   // Reset values of the configuration registers.
   localparam logic [CFG_BITS-1:0] WINDOW_SECONDS_RESET = CFG_BITS'(1);
   localparam logic [CFG_BITS-1:0] PULSES_PER_REV_RESET = CFG_BITS'(2);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // take one input transaction
      logic load;     // form dividend and divisor from the window snapshot
      logic step;     // one restoring division step
      logic publish;  // move the quotient into the result register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic window_end;  // the offered sample closes the window
      logic div_last;    // the current division step is the last one
   } dp_status_type;

endpackage

FILE: rtl/wtach_dp.sv
// Datapath of the windowed tachometer: edge and second counters, divider, result register.
module wtach_dp
   import wtach_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   input  logic                      req_pin_level,
   input  logic                      req_second_tick,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata,
   output logic [PULSE_BITS-1:0]     rsp_window_pulses,
   output logic [RPM_BITS-1:0]       rsp_revs_per_minute
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [SEC_BITS-1:0]   SEC_MAX   = {SEC_BITS{1'b1}};
   localparam int                    SAT_BITS  = COUNT_BITS + PULSE_BITS;
   localparam logic [SAT_BITS-1:0]   PULSE_MAX = SAT_BITS'({PULSE_BITS{1'b1}});

   logic [CFG_BITS-1:0]   window_seconds_ff, window_seconds_in;
   logic [CFG_BITS-1:0]   pulses_per_rev_ff, pulses_per_rev_in;
   logic                  last_level_ff, last_level_in;
   logic                  primed_ff, primed_in;
   logic [COUNT_BITS-1:0] edge_count_ff, edge_count_in;
   logic [SEC_BITS-1:0]   seconds_ff, seconds_in;
   logic [COUNT_BITS-1:0] snap_count_ff, snap_count_in;
   logic [DIV_BITS-1:0]   dividend_ff, dividend_in;
   logic [DVSR_BITS-1:0]  divisor_ff, divisor_in;
   logic [DVSR_BITS-1:0]  rem_ff, rem_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [PULSE_BITS-1:0] pulses_out_ff, pulses_out_in;
   logic [RPM_BITS-1:0]   rpm_out_ff, rpm_out_in;

   logic [CFG_BITS-1:0]            ws_eff;
   logic [CFG_BITS-1:0]            ppr_eff;
   logic [COUNT_BITS-1:0]          count_next;
   logic [SEC_BITS-1:0]            seconds_next;
   logic [DVSR_BITS:0]             shifted;
   logic [DVSR_BITS:0]             diff;
   logic                           fits;
   logic [SAT_BITS-1:0]            count_ext;
   logic [DIV_BITS+RPM_BITS-1:0]   quot_ext;

   // A zero register value acts as one.
   assign ws_eff  = (window_seconds_ff == '0) ? CFG_BITS'(1) : window_seconds_ff;
   assign ppr_eff = (pulses_per_rev_ff == '0) ? CFG_BITS'(1) : pulses_per_rev_ff;

   // Edge and tick counting for the offered sample; the priming sample counts no edge.
   always_comb begin
      count_next = edge_count_ff;
      if (primed_ff && req_pin_level && !last_level_ff && (edge_count_ff != COUNT_MAX)) begin
         count_next = edge_count_ff + COUNT_BITS'(1);
      end
      seconds_next = seconds_ff;
      if (req_second_tick && (seconds_ff != SEC_MAX)) begin
         seconds_next = seconds_ff + SEC_BITS'(1);
      end
   end

   assign status.window_end = (seconds_next >= ws_eff);
   assign status.div_last   = (step_ff == STEP_BITS'(DIV_BITS - 1));

   // One restoring division step: the quotient shifts into the dividend register.
   assign shifted = {rem_ff, dividend_ff[DIV_BITS-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = (shifted >= {1'b0, divisor_ff});

   // Result formatting: pulses saturate, the quotient keeps its low bits.
   assign count_ext = SAT_BITS'(snap_count_ff);
   assign quot_ext  = {{RPM_BITS{1'b0}}, dividend_ff};

   always_comb begin
      window_seconds_in = window_seconds_ff;
      pulses_per_rev_in = pulses_per_rev_ff;
      last_level_in     = last_level_ff;
      primed_in         = primed_ff;
      edge_count_in     = edge_count_ff;
      seconds_in        = seconds_ff;
      snap_count_in     = snap_count_ff;
      dividend_in       = dividend_ff;
      divisor_in        = divisor_ff;
      rem_in            = rem_ff;
      step_in           = step_ff;
      pulses_out_in     = pulses_out_ff;
      rpm_out_in        = rpm_out_ff;

      // Configuration writes; unknown indexes are dropped.
      if (csr_write) begin
         unique case (csr_index)
            REG_WINDOW_SECONDS: window_seconds_in = csr_wdata;
            REG_PULSES_PER_REV: pulses_per_rev_in = csr_wdata;
            default: ;
         endcase
      end

      // Input transaction: update counters, snapshot and clear at window end.
      if (cmd.accept) begin
         primed_in     = 1'b1;
         last_level_in = req_pin_level;
         if (status.window_end) begin
            snap_count_in = count_next;
            edge_count_in = '0;
            seconds_in    = '0;
         end else begin
            edge_count_in = count_next;
            seconds_in    = seconds_next;
         end
      end

      // Dividend is count*60 = count*64 - count*4.
      if (cmd.load) begin
         dividend_in = DIV_BITS'({snap_count_ff, 6'b0}) - DIV_BITS'({snap_count_ff, 2'b0});
         divisor_in  = DVSR_BITS'(ws_eff) * DVSR_BITS'(ppr_eff);
         rem_in      = '0;
         step_in     = '0;
      end

      if (cmd.step) begin
         rem_in      = fits ? diff[DVSR_BITS-1:0] : shifted[DVSR_BITS-1:0];
         dividend_in = {dividend_ff[DIV_BITS-2:0], fits};
         step_in     = step_ff + STEP_BITS'(1);
      end

      if (cmd.publish) begin
         pulses_out_in = (count_ext > PULSE_MAX) ? PULSE_MAX[PULSE_BITS-1:0]
                                                 : count_ext[PULSE_BITS-1:0];
         rpm_out_in    = quot_ext[RPM_BITS-1:0];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_seconds_ff <= WINDOW_SECONDS_RESET;
         pulses_per_rev_ff <= PULSES_PER_REV_RESET;
         last_level_ff     <= 1'b0;
         primed_ff         <= 1'b0;
         edge_count_ff     <= '0;
         seconds_ff        <= '0;
         step_ff           <= '0;
      end else begin
         window_seconds_ff <= window_seconds_in;
         pulses_per_rev_ff <= pulses_per_rev_in;
         last_level_ff     <= last_level_in;
         primed_ff         <= primed_in;
         edge_count_ff     <= edge_count_in;
         seconds_ff        <= seconds_in;
         step_ff           <= step_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      snap_count_ff <= snap_count_in;
      dividend_ff   <= dividend_in;
      divisor_ff    <= divisor_in;
      rem_ff        <= rem_in;
      pulses_out_ff <= pulses_out_in;
      rpm_out_ff    <= rpm_out_in;
   end

   assign rsp_window_pulses   = pulses_out_ff;
   assign rsp_revs_per_minute = rpm_out_ff;

endmodule

FILE: rtl/wtach_ctrl.sv
// Controller of the windowed tachometer: sequences the divider and the result handshake.
module wtach_ctrl
   import wtach_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // The result register can take a new result when empty or being emptied.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.accept  = req_valid && req_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.window_end) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A window-ending transaction starts the divider.
   a_window_starts_div: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && status.window_end |=> state_ff == ST_LOAD)
      else $error("window end did not start the divider");

   // A pending result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> slot_free)
      else $error("result register overwritten");

   // The last division step leads to the publish state.
   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && status.div_last |=> state_ff == ST_DONE)
      else $error("divider did not finish");

   // A result appears only from a publish command.
   a_valid_from_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.publish))
      else $error("result valid without publish");

endmodule

FILE: rtl/windowed_tachometer_unit.sv
// Top level of the windowed tachometer: controller and datapath.
// Throughput: one sample transaction per cycle while no window closes.
// A window-ending sample holds off input while the controller passes through its load,
// divide and publish states, driven by the one-bit-per-cycle restoring divider.
// The hold-off and the result both wait longer while an earlier result waits in the result register.
// Reset is synchronous, active high: counters clear, registers return to 1 and 2.
module windowed_tachometer_unit
   import wtach_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_pin_level,
   input  logic                      req_second_tick,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PULSE_BITS-1:0]     rsp_window_pulses,
   output logic [RPM_BITS-1:0]       rsp_revs_per_minute,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   wtach_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wtach_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_pin_level       (req_pin_level),
      .req_second_tick     (req_second_tick),
      .csr_write           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_window_pulses   (rsp_window_pulses),
      .rsp_revs_per_minute (rsp_revs_per_minute)
   );

endmodule

FILE: verif/wtach_checker.sv
// Checker for the windowed tachometer: watches every channel, predicts window results and compares.
`timescale 1ns / 100ps

module wtach_checker
   import wtach_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_pin_level,
   input  logic                      req_second_tick,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [PULSE_BITS-1:0]     rsp_window_pulses,
   input  logic [RPM_BITS-1:0]       rsp_revs_per_minute,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata,
   output int                        mismatches,
   output int                        outstanding
);

   localparam longint unsigned RPM_PER_HZ = 60;
   localparam longint unsigned EDGE_MAX   = (64'd1 << COUNT_BITS) - 1;
   localparam longint unsigned PULSE_MAX  = (64'd1 << PULSE_BITS) - 1;
   localparam logic [SEC_BITS-1:0] SEC_MAX = '1;

   typedef struct {
      logic [PULSE_BITS-1:0] pulses;
      logic [RPM_BITS-1:0]   rpm;
   } tach_reading_type;

   // Shadow of the block's registers and counters.
   logic [CFG_BITS-1:0]   window_len;
   logic [CFG_BITS-1:0]   pulses_per_turn;
   logic                  prev_level;
   logic                  seen_sample;
   logic [COUNT_BITS-1:0] edge_total;
   logic [SEC_BITS-1:0]   seconds_seen;

   tach_reading_type readings_due[$];
   int               windows_checked;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0d ns: window %0d: %s", $time, windows_checked, msg);
      mismatches++;
   endtask

   // Counts an edge, then a tick, then closes the window when enough seconds passed.
   task automatic take_sample(input logic pin, input logic tick);
      longint unsigned  eff_len;
      longint unsigned  eff_ppr;
      longint unsigned  count;
      tach_reading_type reading;
      eff_len = (window_len == 0) ? 1 : window_len;
      eff_ppr = (pulses_per_turn == 0) ? 1 : pulses_per_turn;
      if (seen_sample && pin && !prev_level && edge_total != EDGE_MAX[COUNT_BITS-1:0])
         edge_total++;
      seen_sample = 1'b1;
      prev_level  = pin;
      if (tick && seconds_seen != SEC_MAX)
         seconds_seen++;
      if (seconds_seen >= eff_len) begin
         count          = edge_total;
         reading.pulses = (count > PULSE_MAX) ? PULSE_MAX[PULSE_BITS-1:0] : count[PULSE_BITS-1:0];
         reading.rpm    = RPM_BITS'((count * RPM_PER_HZ) / (eff_len * eff_ppr));
         readings_due.push_back(reading);
         edge_total   = '0;
         seconds_seen = '0;
      end
   endtask

   // Compares one result transaction with the oldest prediction.
   task automatic check_reading();
      tach_reading_type want;
      if (readings_due.size() == 0) begin
         report_mismatch($sformatf("unexpected result pulses=%0d rpm=%0d",
                                   rsp_window_pulses, rsp_revs_per_minute));
      end else begin
         want = readings_due.pop_front();
         if (rsp_window_pulses !== want.pulses)
            report_mismatch($sformatf("window_pulses got %0d, expected %0d",
                                      rsp_window_pulses, want.pulses));
         if (rsp_revs_per_minute !== want.rpm)
            report_mismatch($sformatf("revs_per_minute got %0d, expected %0d",
                                      rsp_revs_per_minute, want.rpm));
      end
      windows_checked++;
   endtask

   // Outputs settle after the edge, so sampling at the edge sees this cycle's handshake.
   always @(posedge clock) begin
      if (reset) begin
         window_len      = WINDOW_SECONDS_RESET;
         pulses_per_turn = PULSES_PER_REV_RESET;
         prev_level      = 1'b0;
         seen_sample     = 1'b0;
         edge_total      = '0;
         seconds_seen    = '0;
         windows_checked = 0;
         readings_due.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_reading();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WINDOW_SECONDS: window_len = csr_wdata;
               REG_PULSES_PER_REV: pulses_per_turn = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            take_sample(req_pin_level, req_second_tick);
      end
      outstanding <= readings_due.size();
   end

endmodule

FILE: verif/windowed_tachometer_unit_tb.sv
// Testbench top of the windowed tachometer: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module windowed_tachometer_unit_tb
   import wtach_pkg::*;
;

   localparam int SETTLE_CYCLES = 2 + DIV_BITS + 6;
   localparam int STALL_LIMIT   = 4000;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_A = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_B = CSR_INDEX_BITS'(3);

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_pin_level = 1'b0;
   logic                      req_second_tick = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [PULSE_BITS-1:0]     rsp_window_pulses;
   logic [RPM_BITS-1:0]       rsp_revs_per_minute;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   int   mismatches;
   int   outstanding;
   int   stall_cycles = 0;
   logic source_quiet = 1'b0;
   logic sink_quiet = 1'b0;
   logic pin_now = 1'b0;

   always #4 clock = ~clock;

   windowed_tachometer_unit dut (.*);

   wtach_checker u_checker (.*);

   // Ends the run if no transaction of any kind completes for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("windowed_tachometer_unit regression: fail");
         $finish;
      end
   end

   // Result side: a random hold-off before each transaction, none while quiet.
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = sink_quiet ? 0 : $urandom_range(0, 18);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Offers one sample transaction and returns at the edge that accepts it.
   task automatic offer_sample(input logic pin, input logic tick);
      int gap;
      gap = source_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pin_level   <= pin;
      req_second_tick <= tick;
      pin_now = pin;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Stops input, waits for every predicted window, then lets the divider finish.
   task automatic drain_windows();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                              input logic [CFG_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int   n_items;
      int   tick_pct;
      logic toggle_pin;
      logic pin;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: the priming sample carries a tick and closes a window of one second.
      offer_sample(1'b1, 1'b1);
      offer_sample(1'b0, 1'b0);
      offer_sample(1'b1, 1'b0);
      offer_sample(1'b0, 1'b0);
      offer_sample(1'b1, 1'b1);
      offer_sample(1'b1, 1'b0);
      offer_sample(1'b0, 1'b1);
      drain_windows();

      // Zero in either register behaves as one; spare indexes are ignored.
      program_reg(REG_WINDOW_SECONDS, 8'd0);
      program_reg(REG_PULSES_PER_REV, 8'd0);
      program_reg(REG_SPARE_A, 8'hFF);
      program_reg(REG_SPARE_B, 8'hA5);
      offer_sample(1'b1, 1'b0);
      offer_sample(1'b0, 1'b0);
      offer_sample(1'b1, 1'b0);
      offer_sample(1'b0, 1'b0);
      offer_sample(1'b1, 1'b1);
      drain_windows();

      // Shortening the window below the seconds already counted closes it at the next sample.
      program_reg(REG_WINDOW_SECONDS, 8'd200);
      program_reg(REG_PULSES_PER_REV, 8'd1);
      repeat (6) offer_sample(~pin_now, 1'b1);
      drain_windows();
      program_reg(REG_WINDOW_SECONDS, 8'd3);
      offer_sample(1'b0, 1'b0);
      offer_sample(1'b1, 1'b0);
      drain_windows();

      // Random phases, each under its own register setting and idling pattern.
      for (int phase = 0; phase < 8; phase++) begin
         drain_windows();
         if (phase == 0) begin
            program_reg(REG_WINDOW_SECONDS, 8'd255);
            program_reg(REG_PULSES_PER_REV, 8'd255);
            n_items    = 300;
            tick_pct   = 95;
            toggle_pin = 1'b1;
         end else if (phase == 1) begin
            program_reg(REG_WINDOW_SECONDS, 8'd1);
            program_reg(REG_PULSES_PER_REV, 8'd1);
            n_items    = 80;
            tick_pct   = 10;
            toggle_pin = 1'b1;
         end else begin
            program_reg(REG_WINDOW_SECONDS, CFG_BITS'($urandom_range(0, 6)));
            program_reg(REG_PULSES_PER_REV, CFG_BITS'($urandom_range(0, 255)));
            n_items    = 70;
            tick_pct   = 40;
            toggle_pin = ($urandom_range(0, 2) == 0);
         end
         source_quiet = (phase == 1) || ($urandom_range(0, 3) == 0);
         sink_quiet   = (phase == 3) || ($urandom_range(0, 3) == 0);
         for (int i = 0; i < n_items; i++) begin
            pin = toggle_pin ? ~pin_now : logic'($urandom_range(0, 1));
            offer_sample(pin, $urandom_range(0, 99) < tick_pct);
         end
      end

      drain_windows();
      if (mismatches == 0)
         $display("windowed_tachometer_unit regression: pass");
      else
         $display("windowed_tachometer_unit regression: fail");
      $finish;
   end

endmodule
